/* hw/rtl/fsocull_pkg.sv */
// fsocull_pkg: types, widths, register codes and arithmetic helpers of the frustum cull test.
// No dependencies; every other file of the block but fsocull_if imports it.
`timescale 1ns / 1ps

package fsocull_pkg;

    // Field and register widths
    localparam int COORD_W = 32;
    localparam int EXT_W   = 31;
    localparam int LANE_W  = 16;
    localparam int FAC_W   = 16;
    localparam int CFG_W   = 64;
    localparam int REG_IDX_W = 3;

    // Datapath widths
    localparam int REL_W = COORD_W + 1;        // point minus eye
    localparam int MQ_W  = 36;                 // exact rotation term, Q.28
    localparam int MR_W  = MQ_W - 14;          // rounded rotation term, Q1.14
    localparam int MX_W  = MR_W + EXT_W + 1;   // rotation term times half extent
    localparam int ACC_W = MX_W + 3;           // corner sum, Q.30
    localparam int P_W   = ACC_W - 14;         // corner position, Q16.16
    localparam int PJ_W  = P_W + LANE_W + 2;   // projection sum, Q.30
    localparam int FW_W  = PJ_W - 14;          // projection, Q16.16
    localparam int CMP_W = 64;                 // compare width, Q.28 side values

    localparam int NUM_CORNERS = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_EYE_X   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_EYE_Y   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_EYE_Z   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FORWARD = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_UP      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FACTORS = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_DEPTH   = 3'd7;

    // Reset values of the frustum vectors
    localparam logic [47:0] FORWARD_RST = 48'h0000_0000_4000;
    localparam logic [47:0] UP_RST      = 48'h0000_4000_0000;
    localparam logic [47:0] RIGHT_RST   = 48'h4000_0000_0000;

    // Volume kind
    localparam logic CMD_SPHERE = 1'b0;
    localparam logic CMD_BOX    = 1'b1;

    localparam logic signed [MQ_W-1:0] ONE_Q28  = 36'sh010000000;
    localparam logic signed [MQ_W-1:0] HALF_Q14 = 36'sd8192;

    // Decoded frustum
    typedef struct {
        logic signed [COORD_W-1:0] eye [3];
        logic signed [LANE_W-1:0]  fwd [3];
        logic signed [LANE_W-1:0]  upv [3];
        logic signed [LANE_W-1:0]  rgt [3];
        logic [FAC_W-1:0]          tan_h;
        logic [FAC_W-1:0]          tan_v;
        logic [FAC_W-1:0]          scl_x;
        logic [FAC_W-1:0]          scl_y;
        logic signed [COORD_W-1:0] near_d;
        logic signed [COORD_W-1:0] far_d;
    } cfg_t;

    // Classified item between front and back
    typedef struct {
        logic                    is_box;
        logic                    encl;
        logic signed [REL_W-1:0] rel [3];
        logic [EXT_W-1:0]        ext [3];
        logic signed [LANE_W-1:0] q [4];
    } job_t;

    // Round an exact Q.28 rotation term to Q1.14
    function automatic logic signed [MR_W-1:0] round_q14(input logic signed [MQ_W-1:0] t);
        logic signed [MQ_W-1:0] s;
        s = (t + HALF_Q14) >>> 14;
        return s[MR_W-1:0];
    endfunction

    // Project a Q16.16 point onto a Q1.14 vector, floor to Q16.16
    function automatic logic signed [FW_W-1:0] project(
        input logic signed [P_W-1:0]    p [3],
        input logic signed [LANE_W-1:0] v [3]
    );
        logic signed [PJ_W-1:0] s;
        s = p[0] * v[0] + p[1] * v[1] + p[2] * v[2];
        s = s >>> 14;
        return s[FW_W-1:0];
    endfunction

endpackage

/* hw/rtl/fsocull_if.sv */
// fsocull_query_if and fsocull_result_if: valid/ready channels of the frustum cull test.
// No dependencies.
`timescale 1ns / 1ps

interface fsocull_query_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic               fully_enclosed;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    logic [30:0]        size_x;
    logic [30:0]        size_y;
    logic [30:0]        size_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;

    modport source(output valid, command, fully_enclosed, centre_x, centre_y, centre_z,
                   size_x, size_y, size_z, quat_w, quat_x, quat_y, quat_z,
                   input ready);
    modport sink(input valid, command, fully_enclosed, centre_x, centre_y, centre_z,
                 size_x, size_y, size_z, quat_w, quat_x, quat_y, quat_z,
                 output ready);
endinterface

interface fsocull_result_if;
    logic valid;
    logic ready;
    logic visible;

    modport source(output valid, visible, input ready);
    modport sink(input valid, visible, output ready);
endinterface

/* hw/rtl/frustum_sphere_obb_cull_test_top.sv */
// frustum_sphere_obb_cull_test_top: frustum visibility test for spheres and oriented boxes.
// Depends on fsocull_pkg, fsocull_if, fsocull_cfg, fsocull_front, fsocull_queue, fsocull_back.
`timescale 1ns / 1ps

// Tests one bounding volume per item against the camera frustum held in the
// configuration registers and returns one visible bit per item, in order. The
// block takes one item per clock and delivers one result per clock while the
// result sink keeps up. An accepted item is written into the job queue at the
// accepting edge, then passes the five pipeline stages (rotation matrix,
// rotated extents, corners, projections, plane compares) and the result
// register before its result is presented. The rate is one item per clock,
// while the sink keeps up, because every stage is registered and the
// projection stage runs all eight corners in parallel. A stalled result
// stalls the pipeline; the job queue of QUEUE_DEPTH entries keeps accepting
// until it fills. Write configuration only while no item is in flight.
module frustum_sphere_obb_cull_test_top #(
    parameter int QUEUE_DEPTH = fsocull_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    fsocull_query_if.sink                     query,
    fsocull_result_if.source                  result,
    input  logic                              cfg_we,
    input  logic [fsocull_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [fsocull_pkg::CFG_W-1:0]     cfg_data
);
    import fsocull_pkg::*;

    cfg_t cfg;
    job_t front_job, back_job;
    logic front_valid, front_ready, back_valid, back_ready;

    fsocull_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fsocull_front u_front (
        .query     (query),
        .cfg       (cfg),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    fsocull_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_job    (front_job),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_job   (back_job)
    );

    fsocull_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .result    (result)
    );

endmodule

/* hw/rtl/fsocull_cfg.sv */
// fsocull_cfg: frustum configuration registers and their field decode.
// Depends on fsocull_pkg.
`timescale 1ns / 1ps

module fsocull_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [fsocull_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [fsocull_pkg::CFG_W-1:0]        cfg_data,
    output fsocull_pkg::cfg_t                    cfg
);
    import fsocull_pkg::*;

    logic [COORD_W-1:0] eye_x_reg, eye_y_reg, eye_z_reg;
    logic [47:0]        fwd_reg, up_reg, rgt_reg;
    logic [CFG_W-1:0]   fac_reg, depth_reg;

    // Write one register per enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_x_reg <= '0;
            eye_y_reg <= '0;
            eye_z_reg <= '0;
            fwd_reg   <= FORWARD_RST;
            up_reg    <= UP_RST;
            rgt_reg   <= RIGHT_RST;
            fac_reg   <= '0;
            depth_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EYE_X:   eye_x_reg <= cfg_data[COORD_W-1:0];
                REG_EYE_Y:   eye_y_reg <= cfg_data[COORD_W-1:0];
                REG_EYE_Z:   eye_z_reg <= cfg_data[COORD_W-1:0];
                REG_FORWARD: fwd_reg   <= cfg_data[47:0];
                REG_UP:      up_reg    <= cfg_data[47:0];
                REG_RIGHT:   rgt_reg   <= cfg_data[47:0];
                REG_FACTORS: fac_reg   <= cfg_data;
                REG_DEPTH:   depth_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Split packed fields
    always_comb
    begin
        cfg.eye[0] = $signed(eye_x_reg);
        cfg.eye[1] = $signed(eye_y_reg);
        cfg.eye[2] = $signed(eye_z_reg);
        for (int k = 0; k < 3; k++)
        begin
            cfg.fwd[k] = $signed(fwd_reg[16*k +: 16]);
            cfg.upv[k] = $signed(up_reg[16*k +: 16]);
            cfg.rgt[k] = $signed(rgt_reg[16*k +: 16]);
        end
        cfg.tan_h  = fac_reg[15:0];
        cfg.tan_v  = fac_reg[31:16];
        cfg.scl_x  = fac_reg[47:32];
        cfg.scl_y  = fac_reg[63:48];
        cfg.near_d = $signed(depth_reg[31:0]);
        cfg.far_d  = $signed(depth_reg[63:32]);
    end

endmodule

/* hw/rtl/fsocull_front.sv */
// fsocull_front: accepts query items, classifies the volume and forms the eye-relative job.
// Depends on fsocull_pkg and fsocull_if.
`timescale 1ns / 1ps

module fsocull_front (
    fsocull_query_if.sink     query,
    input  fsocull_pkg::cfg_t cfg,
    output logic              job_valid,
    input  logic              job_ready,
    output fsocull_pkg::job_t job
);
    import fsocull_pkg::*;

    // Pass the handshake through to the queue
    assign job_valid   = query.valid;
    assign query.ready = job_ready;

    // Classify and subtract the eye
    always_comb
    begin
        job.is_box = (query.command == CMD_BOX);
        job.encl   = query.fully_enclosed;
        job.rel[0] = REL_W'(query.centre_x) - REL_W'(cfg.eye[0]);
        job.rel[1] = REL_W'(query.centre_y) - REL_W'(cfg.eye[1]);
        job.rel[2] = REL_W'(query.centre_z) - REL_W'(cfg.eye[2]);
        job.ext[0] = query.size_x;
        job.ext[1] = query.size_y;
        job.ext[2] = query.size_z;
        job.q[0]   = query.quat_w;
        job.q[1]   = query.quat_x;
        job.q[2]   = query.quat_y;
        job.q[3]   = query.quat_z;
    end

endmodule

/* hw/rtl/fsocull_queue.sv */
// fsocull_queue: short job queue that decouples the front from the back pipeline.
// Depends on fsocull_pkg.
`timescale 1ns / 1ps

module fsocull_queue #(
    parameter int DEPTH = fsocull_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fsocull_pkg::job_t in_job,
    output logic              out_valid,
    input  logic              out_ready,
    output fsocull_pkg::job_t out_job
);
    import fsocull_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push, pop;

    assign in_ready  = (cnt_reg != CNT_W'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_job   = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Store the item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

/* hw/rtl/fsocull_back.sv */
// fsocull_back: five-stage test pipeline (rotation, extents, corners, projections,
// plane compares) and the result register. Depends on fsocull_pkg and fsocull_if.
`timescale 1ns / 1ps

module fsocull_back (
    input  logic              clk,
    input  logic              rst_n,
    input  fsocull_pkg::cfg_t cfg,
    input  logic              job_valid,
    output logic              job_ready,
    input  fsocull_pkg::job_t job,
    fsocull_result_if.source  result
);
    import fsocull_pkg::*;

    logic adv;
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg, out_vld_reg;
    logic out_vis_reg;

    // Stage 1: rotation matrix
    logic                    s1_box_reg, s1_encl_reg;
    logic signed [REL_W-1:0] s1_rel_reg [3];
    logic [EXT_W-1:0]        s1_ext_reg [3];
    logic signed [MR_W-1:0]  s1_m_reg [3][3];
    logic signed [MQ_W-1:0]  mq [3][3];
    logic signed [MQ_W-1:0]  qw, qx, qy, qz;

    // Stage 2: rotated extents
    logic                    s2_box_reg, s2_encl_reg;
    logic signed [REL_W-1:0] s2_rel_reg [3];
    logic [EXT_W-1:0]        s2_r_reg;
    logic signed [MX_W-1:0]  s2_mx_reg [3][3];

    // Stage 3: corner positions
    logic                    s3_box_reg, s3_encl_reg;
    logic [EXT_W-1:0]        s3_r_reg;
    logic signed [P_W-1:0]   s3_p_reg [NUM_CORNERS][3];
    logic signed [P_W-1:0]   p_next [NUM_CORNERS][3];

    // Stage 4: projections
    logic                    s4_box_reg, s4_encl_reg;
    logic [EXT_W-1:0]        s4_r_reg;
    logic signed [FW_W-1:0]  s4_f_reg [NUM_CORNERS];
    logic signed [FW_W-1:0]  s4_h_reg [NUM_CORNERS];
    logic signed [FW_W-1:0]  s4_v_reg [NUM_CORNERS];

    // Stage 5: plane flags
    logic                     s5_box_reg, s5_encl_reg, s5_sph_reg;
    logic [NUM_CORNERS-1:0]   s5_in_reg;
    logic [NUM_CORNERS-1:0]   s5_out_reg [6];
    logic [NUM_CORNERS-1:0]   in_next;
    logic [NUM_CORNERS-1:0]   out_next [6];
    logic                     sph_next;
    logic                     all_out;

    // Whole pipeline moves when the result register is free
    assign adv           = !out_vld_reg || result.ready;
    assign job_ready     = adv;
    assign result.valid  = out_vld_reg;
    assign result.visible = out_vis_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg  <= job_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            out_vld_reg <= s5_vld_reg;
        end
    end

    // Exact quaternion matrix terms, m[column][row]
    always_comb
    begin
        qw = MQ_W'(job.q[0]);
        qx = MQ_W'(job.q[1]);
        qy = MQ_W'(job.q[2]);
        qz = MQ_W'(job.q[3]);
        mq[0][0] = ONE_Q28 - 36'sd2 * (qy * qy + qz * qz);
        mq[0][1] = 36'sd2 * (qx * qy + qw * qz);
        mq[0][2] = 36'sd2 * (qx * qz - qw * qy);
        mq[1][0] = 36'sd2 * (qx * qy - qw * qz);
        mq[1][1] = ONE_Q28 - 36'sd2 * (qx * qx + qz * qz);
        mq[1][2] = 36'sd2 * (qy * qz + qw * qx);
        mq[2][0] = 36'sd2 * (qx * qz + qw * qy);
        mq[2][1] = 36'sd2 * (qy * qz - qw * qx);
        mq[2][2] = ONE_Q28 - 36'sd2 * (qx * qx + qy * qy);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_box_reg  <= job.is_box;
            s1_encl_reg <= job.encl;
            s1_rel_reg  <= job.rel;
            s1_ext_reg  <= job.ext;
            for (int c = 0; c < 3; c++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    s1_m_reg[c][i] <= round_q14(mq[c][i]);
                end
            end
        end
    end

    // Scale matrix columns by the half extents
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_box_reg  <= s1_box_reg;
            s2_encl_reg <= s1_encl_reg;
            s2_rel_reg  <= s1_rel_reg;
            s2_r_reg    <= s1_ext_reg[0];
            for (int c = 0; c < 3; c++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    s2_mx_reg[c][i] <= s1_m_reg[c][i] * $signed({1'b0, s1_ext_reg[c]});
                end
            end
        end
    end

    // Sum signed extents per corner; a sphere rides in corner zero as its centre
    always_comb
    begin
        logic signed [ACC_W-1:0] acc;
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc = ACC_W'(s2_rel_reg[i]) <<< 14;
                for (int c = 0; c < 3; c++)
                begin
                    if (k[c])
                    begin
                        acc = acc + ACC_W'(s2_mx_reg[c][i]);
                    end
                    else
                    begin
                        acc = acc - ACC_W'(s2_mx_reg[c][i]);
                    end
                end
                acc = acc >>> 14;
                p_next[k][i] = acc[P_W-1:0];
            end
        end
        if (!s2_box_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p_next[0][i] = P_W'(s2_rel_reg[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_box_reg  <= s2_box_reg;
            s3_encl_reg <= s2_encl_reg;
            s3_r_reg    <= s2_r_reg;
            s3_p_reg    <= p_next;
        end
    end

    // Project each corner onto forward, right and up
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_box_reg  <= s3_box_reg;
            s4_encl_reg <= s3_encl_reg;
            s4_r_reg    <= s3_r_reg;
            for (int k = 0; k < NUM_CORNERS; k++)
            begin
                s4_f_reg[k] <= project(s3_p_reg[k], cfg.fwd);
                s4_h_reg[k] <= project(s3_p_reg[k], cfg.rgt);
                s4_v_reg[k] <= project(s3_p_reg[k], cfg.upv);
            end
        end
    end

    // Classify each corner against the six planes
    always_comb
    begin
        logic signed [CMP_W-1:0] f, h, v, lim_h, lim_v, nr, fr;
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            f     = CMP_W'(s4_f_reg[k]);
            h     = CMP_W'(s4_h_reg[k]) <<< 12;
            v     = CMP_W'(s4_v_reg[k]) <<< 12;
            lim_h = $signed({48'b0, cfg.tan_h}) * f;
            lim_v = $signed({48'b0, cfg.tan_v}) * f;
            nr    = CMP_W'(cfg.near_d);
            fr    = CMP_W'(cfg.far_d);
            out_next[0][k] = (h < -lim_h);
            out_next[1][k] = !out_next[0][k] && (h > lim_h);
            out_next[2][k] = (v < -lim_v);
            out_next[3][k] = !out_next[2][k] && (v > lim_v);
            out_next[4][k] = (f < nr);
            out_next[5][k] = !out_next[4][k] && (f > fr);
            in_next[k] = !(out_next[0][k] || out_next[1][k] || out_next[2][k]
                           || out_next[3][k] || out_next[4][k] || out_next[5][k]);
        end
    end

    // Sphere test on corner zero
    always_comb
    begin
        logic signed [CMP_W-1:0] f, h, v, r, rx, ry, lim_h, lim_v, nr, fr;
        logic [EXT_W+FAC_W-1:0]  rxu, ryu;
        logic                    bad_d, bad_h, bad_v;
        f     = CMP_W'(s4_f_reg[0]);
        h     = CMP_W'(s4_h_reg[0]) <<< 12;
        v     = CMP_W'(s4_v_reg[0]) <<< 12;
        r     = $signed({33'b0, s4_r_reg});
        rxu   = s4_r_reg * cfg.scl_x;
        ryu   = s4_r_reg * cfg.scl_y;
        rx    = $signed({17'b0, rxu});
        ry    = $signed({17'b0, ryu});
        lim_h = $signed({48'b0, cfg.tan_h}) * f;
        lim_v = $signed({48'b0, cfg.tan_v}) * f;
        nr    = CMP_W'(cfg.near_d);
        fr    = CMP_W'(cfg.far_d);
        if (s4_encl_reg)
        begin
            bad_d = (f - r < nr) || (fr < f + r);
            bad_h = (h - rx < -lim_h) || (lim_h < h + rx);
            bad_v = (v - ry < -lim_v) || (lim_v < v + ry);
        end
        else
        begin
            bad_d = (f + r < nr) || (fr < f - r);
            bad_h = (h + rx < -lim_h) || (lim_h < h - rx);
            bad_v = (v + ry < -lim_v) || (lim_v < v - ry);
        end
        sph_next = !(bad_d || bad_h || bad_v);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_box_reg  <= s4_box_reg;
            s5_encl_reg <= s4_encl_reg;
            s5_sph_reg  <= sph_next;
            s5_in_reg   <= in_next;
            s5_out_reg  <= out_next;
        end
    end

    // Reduce corners to one answer and hold it for the sink
    always_comb
    begin
        all_out = 1'b0;
        for (int j = 0; j < 6; j++)
        begin
            all_out = all_out || (&s5_out_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (!s5_box_reg)
            begin
                out_vis_reg <= s5_sph_reg;
            end
            else if (s5_encl_reg)
            begin
                out_vis_reg <= &s5_in_reg;
            end
            else
            begin
                out_vis_reg <= (|s5_in_reg) || !all_out;
            end
        end
    end

endmodule
